// ----- sv/heat1d_pkg.sv -----
// Shared types, constants and command/status structs for the 1-D heat stencil block.
package heat1d_pkg;

	localparam int MAX_POINTS = 65;
	localparam int TEMP_W     = 32;
	localparam int IDX_W      = 7;
	localparam int MSQ_W      = 13;
	localparam int PROD_W     = 64;
	localparam int PART_W     = PROD_W / 2 + MSQ_W;
	localparam int NUM_W      = PART_W + PROD_W / 2;
	localparam int DIV_W      = 56;
	localparam int FRAC_SH    = 24;
	localparam int DIV_STEPS  = NUM_W;

	localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_LEFT   = 3'd0,
		CFG_RIGHT  = 3'd1,
		CFG_INNER  = 3'd2,
		CFG_POINTS = 3'd3,
		CFG_TIME   = 3'd4,
		CFG_CFL    = 3'd5
	} cfg_idx_t;

	localparam logic [31:0]      RST_LEFT   = 32'd1677721600;
	localparam logic [31:0]      RST_RIGHT  = 32'd167772160;
	localparam logic [31:0]      RST_INNER  = 32'd838860800;
	localparam logic [IDX_W-1:0] RST_POINTS = 7'd65;
	localparam logic [31:0]      RST_TIME   = 32'd20971520;
	localparam logic [31:0]      RST_CFL    = 32'd42949673;

	// Controller to datapath
	typedef struct packed {
		logic             load;
		logic             mul;
		logic             sum;
		logic             div_step;
		logic             steps_fix;
		logic             coef_fix;
		logic             init_wr;
		logic             rd;
		logic             rd_sweep;
		logic             rd_mid;
		logic             dec_steps;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [IDX_W-1:0] last_idx;
		logic             steps_zero;
		logic             steps_last;
		logic             changed;
		logic             pipe_busy;
	} stat_t;

endpackage

// ----- sv/heat1d_ctrl.sv -----
// Controller state machine sequencing setup, divisions, sweeps and the result beat.
module heat1d_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	input  heat1d_pkg::stat_t      stat,
	output heat1d_pkg::cmd_t       cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_MUL   = 12'b000000000010,
		S_SUM   = 12'b000000000100,
		S_DIVS  = 12'b000000001000,
		S_FIXS  = 12'b000000010000,
		S_DIVC  = 12'b000000100000,
		S_FIXC  = 12'b000001000000,
		S_INIT  = 12'b000010000000,
		S_SWEEP = 12'b000100000000,
		S_DRAIN = 12'b001000000000,
		S_MID   = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	localparam logic [heat1d_pkg::IDX_W-1:0] DIV_LAST =
		heat1d_pkg::IDX_W'(heat1d_pkg::DIV_STEPS - 1);

	state_t state_q, state_d;
	logic [heat1d_pkg::IDX_W-1:0] cnt_q, cnt_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_FIXS;
			end
			S_FIXS: begin
				cmd.steps_fix = 1'b1;
				cnt_d         = '0;
				state_d       = S_DIVC;
			end
			S_DIVC: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_FIXC;
			end
			S_FIXC: begin
				cmd.coef_fix = 1'b1;
				cnt_d        = '0;
				state_d      = S_INIT;
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == stat.last_idx) begin
					cnt_d   = '0;
					state_d = stat.steps_zero ? S_MID : S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.rd       = 1'b1;
				cmd.rd_sweep = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == stat.last_idx) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.dec_steps = 1'b1;
					cnt_d         = '0;
					if (stat.steps_last || !stat.changed) state_d = S_MID;
					else state_d = S_SWEEP;
				end
			end
			S_MID: begin
				cmd.rd     = 1'b1;
				cmd.rd_mid = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

// ----- sv/heat1d_dp.sv -----
// Datapath: registers, step/coefficient arithmetic, shared divider and stencil pipeline.
module heat1d_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  heat1d_pkg::cfg_idx_t                cfg_idx,
	input  logic [31:0]                         cfg_data,
	input  logic [31:0]                         diffusivity,
	input  heat1d_pkg::cmd_t                    cmd,
	output heat1d_pkg::stat_t                   stat,
	output logic [31:0]                         mid_temp,
	output logic [31:0]                         step_count
);

	localparam int IW = heat1d_pkg::IDX_W;
	localparam int TW = heat1d_pkg::TEMP_W;
	localparam int NW = heat1d_pkg::NUM_W;
	localparam int DW = heat1d_pkg::DIV_W;
	localparam int PW = heat1d_pkg::PART_W;

	// Configuration registers
	logic [31:0]   left_q, right_q, inner_q, time_q, cfl_q;
	logic [IW-1:0] points_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= heat1d_pkg::RST_LEFT;
			right_q  <= heat1d_pkg::RST_RIGHT;
			inner_q  <= heat1d_pkg::RST_INNER;
			points_q <= heat1d_pkg::RST_POINTS;
			time_q   <= heat1d_pkg::RST_TIME;
			cfl_q    <= heat1d_pkg::RST_CFL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				heat1d_pkg::CFG_LEFT:   left_q   <= cfg_data;
				heat1d_pkg::CFG_RIGHT:  right_q  <= cfg_data;
				heat1d_pkg::CFG_INNER:  inner_q  <= cfg_data;
				heat1d_pkg::CFG_POINTS: points_q <= cfg_data[IW-1:0];
				heat1d_pkg::CFG_TIME:   time_q   <= cfg_data;
				heat1d_pkg::CFG_CFL:    cfl_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grid size clamp
	logic [IW-1:0] pts_c, last_q;
	logic [heat1d_pkg::MSQ_W-1:0] msq_q;
	always_comb begin
		pts_c = points_q;
		if (points_q < IW'(3)) pts_c = IW'(3);
		if (points_q > IW'(heat1d_pkg::MAX_POINTS)) pts_c = IW'(heat1d_pkg::MAX_POINTS);
	end

	// Product N = D * R * m^2, built in load, partial-product and sum steps
	logic [heat1d_pkg::PROD_W-1:0] p_q;
	logic [PW-1:0] a_q, b_q;
	logic [NW-1:0] n_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q    <= 64'(diffusivity) * 64'(time_q);
			last_q <= pts_c - 1'b1;
			msq_q  <= heat1d_pkg::MSQ_W'(16'(pts_c - 1'b1) * 16'(pts_c - 1'b1));
		end
		if (cmd.mul) begin
			a_q <= PW'(p_q[31:0]) * PW'(msq_q);
			b_q <= PW'(p_q[63:32]) * PW'(msq_q);
		end
		if (cmd.sum) n_q <= NW'(a_q) + {b_q, 32'd0};
	end

	// Restoring divider, one quotient bit a beat, saturating at 32 bits
	logic [DW-1:0] d_q, r_q;
	logic [31:0]   q_q;
	logic          sat_q;
	logic [DW:0]   r2;
	logic          ge;
	logic [31:0]   div_res, steps_d;
	logic [31:0]   steps_q, coef_q, sl_q;

	assign r2      = {r_q, n_q[IW'(NW - 1) - cmd.idx]};
	assign ge      = (r2 >= {1'b0, d_q});
	assign div_res = sat_q ? 32'hFFFF_FFFF : q_q;

	always_comb begin
		if (n_q == '0) steps_d = '0;
		else if (cfl_q == '0) steps_d = 32'hFFFF_FFFF;
		else if (!sat_q && (r_q != '0) && (q_q != 32'hFFFF_FFFF)) steps_d = q_q + 1'b1;
		else steps_d = div_res;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			d_q   <= {cfl_q[DW-heat1d_pkg::FRAC_SH-1:0], 24'd0};
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (cmd.steps_fix) begin
			d_q   <= {steps_d, 24'd0};
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			r_q   <= ge ? DW'(r2 - {1'b0, d_q}) : r2[DW-1:0];
			q_q   <= {q_q[30:0], ge};
			sat_q <= sat_q | q_q[31];
		end
		if (cmd.steps_fix) steps_q <= steps_d;
	end

	// Step state: coefficient and sweeps still to run
	logic changed_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			sl_q   <= '0;
		end else if (cmd.coef_fix) begin
			coef_q <= (steps_q == '0) ? '0 : div_res;
			sl_q   <= steps_q;
		end else if (cmd.dec_steps) begin
			sl_q <= changed_q ? sl_q - 1'b1 : '0;
		end
	end

	// Temperature field memory
	logic [TW-1:0] mem [heat1d_pkg::MAX_POINTS];
	logic [TW-1:0] rdata_q, init_val, nv;
	logic [IW-1:0] rd_addr, wi_s2;
	logic          v_s2;

	assign rd_addr = cmd.rd_mid ? (last_q >> 1) : cmd.idx;

	always_comb begin
		if (cmd.idx == '0) init_val = left_q;
		else if (cmd.idx == last_q) init_val = right_q;
		else init_val = inner_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rdata_q <= mem[rd_addr];
		if (cmd.init_wr) mem[cmd.idx] <= init_val;
		else if (v_s2) mem[wi_s2] <= nv;
	end

	// Stencil pipeline: window, laplacian, multiply, update
	logic          rv_q, v_s1;
	logic [IW-1:0] rj_q, wi_s1;
	logic [TW-1:0] w0_q, w1_q, cur_s1, cur_s2;
	logic signed [TW+2:0] lap;
	logic          neg_s1, neg_s2;
	logic [TW+1:0] mag_s1;
	logic [63:0]   plo_s2;
	logic [TW+1:0] phi_s2;
	logic [TW+2:0] delta;
	logic [64:0]   plo_rnd;

	assign lap = $signed((TW+3)'(rdata_q)) + $signed((TW+3)'(w0_q))
		- $signed((TW+3)'({w1_q, 1'b0}));

	assign plo_rnd = 65'(plo_s2) + 65'h0_8000_0000;
	assign delta   = (TW+3)'(phi_s2) + (TW+3)'(plo_rnd[64:32]);

	always_comb begin
		if (neg_s2) nv = (delta > (TW+3)'(cur_s2)) ? '0 : TW'((TW+3)'(cur_s2) - delta);
		else if (delta > (TW+3)'(heat1d_pkg::TEMP_MAX - cur_s2)) nv = heat1d_pkg::TEMP_MAX;
		else nv = TW'((TW+3)'(cur_s2) + delta);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q      <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			rv_q <= cmd.rd_sweep;
			v_s1 <= rv_q && (rj_q >= IW'(2));
			v_s2 <= v_s1;
			if (cmd.rd_sweep && cmd.idx == '0) changed_q <= 1'b0;
			else if (v_s2 && nv != cur_s2) changed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rj_q <= cmd.idx;
		if (rv_q) begin
			w0_q   <= w1_q;
			w1_q   <= rdata_q;
			neg_s1 <= lap[TW+2];
			mag_s1 <= lap[TW+2] ? (TW+2)'(-lap) : (TW+2)'(lap);
			cur_s1 <= w1_q;
			wi_s1  <= rj_q - 1'b1;
		end
		plo_s2 <= 64'(coef_q) * 64'(mag_s1[31:0]);
		phi_s2 <= (TW+2)'(coef_q) * (TW+2)'(mag_s1[TW+1:TW]);
		neg_s2 <= neg_s1;
		cur_s2 <= cur_s1;
		wi_s2  <= wi_s1;
	end

	// Status and result
	assign stat.last_idx   = last_q;
	assign stat.steps_zero = (steps_q == '0);
	assign stat.steps_last = (sl_q == 32'd1);
	assign stat.changed    = changed_q;
	assign stat.pipe_busy  = rv_q | v_s1 | v_s2;

	assign mid_temp   = rdata_q;
	assign step_count = steps_q;

endmodule

// ----- sv/heat_1d_explicit_stencil_top.sv -----
// The sweep loop reads one grid point a cycle from the field memory's single read port.
// Throughput: one item at a time; busy stays high from accept to the done beat.
// The result sits on mid_temp/step_count for the one cycle that done is high.
// Reset (arst_n low) idles the controller and loads the registers' default values.
// The receiver cannot stall; cfg_ready is always high.
module heat_1d_explicit_stencil_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] diffusivity,
	output logic        done,
	output logic [31:0] mid_temp,
	output logic [31:0] step_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	heat1d_pkg::cmd_t  cmd;
	heat1d_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	heat1d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	heat1d_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_idx     (heat1d_pkg::cfg_idx_t'(cfg_index)),
		.cfg_data    (cfg_data),
		.diffusivity (diffusivity),
		.cmd         (cmd),
		.stat        (stat),
		.mid_temp    (mid_temp),
		.step_count  (step_count)
	);

endmodule

// ----- sv/heat1d_chk.sv -----
// Port-level checker for the heat stencil top level, with its bind.
module heat1d_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	// An accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");

	// A result beat only while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	// Each result beat lasts one cycle and frees the block
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("done held or busy after done");

	// Configuration channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("cfg_ready low");

endmodule

bind heat_1d_explicit_stencil_top heat1d_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);

// ----- tb/heat_1d_explicit_stencil_top_tb.sv -----
// Self-checking testbench for the 1-D explicit heat stencil block with its own predictor.
module heat_1d_explicit_stencil_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [31:0]           diffusivity;
	logic                  done;
	logic [31:0]           mid_temp;
	logic [31:0]           step_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	heat1d_pkg::cfg_idx_t  cfg_index;
	logic [31:0]           cfg_data;

	typedef struct packed {
		logic [31:0] mid;
		logic [31:0] steps;
	} heat_result_t;

	// Shadow copy of the block's registers
	logic [31:0]                  sh_left, sh_right, sh_inner, sh_time, sh_cfl;
	logic [heat1d_pkg::IDX_W-1:0] sh_points;

	logic [31:0]  pending_diff[$];
	heat_result_t expected_heat[$];
	int           errors;
	int           sender_idle_pct;

	heat_1d_explicit_stencil_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.diffusivity(diffusivity), .done(done), .mid_temp(mid_temp),
		.step_count(step_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// Step count, coefficient and the FTCS sweeps for one diffusivity
	function automatic heat_result_t solve_heat(input logic [31:0] d);
		logic [63:0]  field[heat1d_pkg::MAX_POINTS];
		logic [63:0]  prev[heat1d_pkg::MAX_POINTS];
		logic [127:0] num, quo, rmd, dvs;
		logic [31:0]  steps, coef, left;
		logic [63:0]  mag, delta, cur, nv, k;
		longint       lap;
		int           pts, msq;
		bit           changed;
		heat_result_t res;
		pts = sh_points;
		if (pts < 3) pts = 3;
		if (pts > heat1d_pkg::MAX_POINTS) pts = heat1d_pkg::MAX_POINTS;
		msq = (pts - 1) * (pts - 1);
		num = 128'(d) * 128'(sh_time) * 128'(msq);
		if (num == 0) begin
			steps = '0;
		end else if (sh_cfl == 0) begin
			steps = '1;
		end else begin
			dvs = 128'(sh_cfl) << heat1d_pkg::FRAC_SH;
			quo = num / dvs;
			rmd = num % dvs;
			if (quo > 128'hFFFF_FFFF) steps = '1;
			else if (rmd != 0 && quo != 128'hFFFF_FFFF) steps = quo[31:0] + 1;
			else steps = quo[31:0];
		end
		if (steps == 0) begin
			coef = '0;
		end else begin
			quo = num / (128'(steps) << heat1d_pkg::FRAC_SH);
			coef = (quo > 128'hFFFF_FFFF) ? '1 : quo[31:0];
		end
		for (int i = 0; i < pts; i++) field[i] = 64'(sh_inner);
		field[0] = 64'(sh_left);
		field[pts-1] = 64'(sh_right);
		k = 64'(coef);
		left = steps;
		while (left != 0) begin
			changed = 0;
			prev = field;
			for (int i = 1; i <= pts - 2; i++) begin
				lap = longint'(prev[i+1]) - 2 * longint'(prev[i]) + longint'(prev[i-1]);
				mag = (lap < 0) ? 64'(-lap) : 64'(lap);
				delta = k * (mag >> 32) + ((k * (mag & 64'hFFFF_FFFF) + 64'h8000_0000) >> 32);
				cur = prev[i];
				if (lap < 0) nv = (delta > cur) ? 64'd0 : cur - delta;
				else nv = (delta > 64'(heat1d_pkg::TEMP_MAX) - cur) ?
					64'(heat1d_pkg::TEMP_MAX) : cur + delta;
				if (nv != cur) changed = 1;
				field[i] = nv;
			end
			left--;
			if (!changed) left = 0;
		end
		res.mid = field[(pts-1)/2][31:0];
		res.steps = steps;
		return res;
	endfunction

	// Driver: start held until accepted, next beat taken from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			diffusivity <= '0;
		end else begin
			if (start && !busy)
				expected_heat.insert(expected_heat.size(), solve_heat(diffusivity));
			if (!start || !busy) begin
				if (pending_diff.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					diffusivity <= pending_diff.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Register shadow follows accepted configuration beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_left <= heat1d_pkg::RST_LEFT;
			sh_right <= heat1d_pkg::RST_RIGHT;
			sh_inner <= heat1d_pkg::RST_INNER;
			sh_points <= heat1d_pkg::RST_POINTS;
			sh_time <= heat1d_pkg::RST_TIME;
			sh_cfl <= heat1d_pkg::RST_CFL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				heat1d_pkg::CFG_LEFT: sh_left <= cfg_data;
				heat1d_pkg::CFG_RIGHT: sh_right <= cfg_data;
				heat1d_pkg::CFG_INNER: sh_inner <= cfg_data;
				heat1d_pkg::CFG_POINTS: sh_points <= cfg_data[heat1d_pkg::IDX_W-1:0];
				heat1d_pkg::CFG_TIME: sh_time <= cfg_data;
				heat1d_pkg::CFG_CFL: sh_cfl <= cfg_data;
				default: ;
			endcase
		end
	end

	// Monitor: each done beat against the oldest prediction
	always @(posedge clk) begin
		heat_result_t want;
		if (arst_n && done) begin
			if (expected_heat.size() == 0) begin
				report("unexpected result", '0, mid_temp);
			end else begin
				want = expected_heat.pop_front();
				if (mid_temp !== want.mid) report("mid_temp", want.mid, mid_temp);
				if (step_count !== want.steps) report("step_count", want.steps, step_count);
			end
		end
	end

	// One write beat; the caller drops valid after the last one
	task automatic write_reg(input heat1d_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_grid(input logic [31:0] lt, input logic [31:0] rt, input logic [31:0] it,
			input logic [31:0] pts, input logic [31:0] rtime, input logic [31:0] cfl);
		write_reg(heat1d_pkg::CFG_LEFT, lt);
		write_reg(heat1d_pkg::CFG_RIGHT, rt);
		write_reg(heat1d_pkg::CFG_INNER, it);
		write_reg(heat1d_pkg::CFG_POINTS, pts);
		write_reg(heat1d_pkg::CFG_TIME, rtime);
		write_reg(heat1d_pkg::CFG_CFL, cfl);
		cfg_valid <= 1'b0;
	endtask

	// Block the sender until every predicted result has come back
	task automatic drain();
		while (pending_diff.size() != 0 || start || expected_heat.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		sender_idle_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = heat1d_pkg::CFG_LEFT;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: zero product and single-sweep cases only
		pending_diff = '{32'd0, 32'd1, 32'd8000};
		drain();

		// Cold left edge, hot right edge and interior, three points, largest time and stability number
		set_grid(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		pending_diff = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'h8000_0000};
		drain();

		// Zero stability number saturates the count; grid below range clamps to three
		set_grid(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
		pending_diff = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'h5555_5555};
		drain();

		// Grid above range clamps to the maximum; shortest run time
		set_grid(32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 32'd127, 32'd1, 32'hFFFF_FFFF);
		pending_diff = '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'd0};
		drain();

		// Random settings over eight phases, cycling through the sender idling modes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 46;
				2: sender_idle_pct = 18;
				default: sender_idle_pct = 0;
			endcase
			set_grid($urandom, $urandom, $urandom,
				(ph == 0) ? 32'd65 : $urandom_range(3, 65),
				$urandom_range(1, 32'h0002_0000), $urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
			for (int n = 0; n < 11; n++)
				pending_diff.insert(pending_diff.size(),
					($urandom_range(9) == 0) ? 32'd0 : $urandom);
			drain();
		end

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#40ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/heat1d_pkg.sv
sv/heat1d_ctrl.sv
sv/heat1d_dp.sv
sv/heat_1d_explicit_stencil_top.sv
sv/heat1d_chk.sv
tb/heat_1d_explicit_stencil_top_tb.sv
